### hw/rtl/mrra_pkg.sv
// shared types, constants and register indexes of the multirate record ring assembler
package mrra_pkg;

    localparam int DEF_RECORDS   = 32;
    localparam int DEF_CHANNELS  = 4;
    localparam int DEF_SLOT_BITS = 32;

    localparam int MAX_RECORDS  = 32;
    localparam int MAX_CHANNELS = 4;
    localparam int QUEUE_DEPTH  = 2;

    localparam int POS_W     = 5;
    localparam int CNT_W     = 6;
    localparam int FRAC_W    = 16;
    localparam int RATIO_W   = 24;
    localparam int ACC_W     = 25;
    localparam int COPY_W    = ACC_W - FRAC_W;
    localparam int CH_PORT_W = 2;
    localparam int SLOT_W    = 32;
    localparam int IDX_W     = 3;
    localparam int CFG_W     = 24;

    localparam logic [IDX_W-1:0] REG_RECORDS_IN_USE = 3'd0;
    localparam logic [IDX_W-1:0] REG_RATIO_CH0      = 3'd1;
    localparam logic [IDX_W-1:0] REG_RATIO_CH1      = 3'd2;
    localparam logic [IDX_W-1:0] REG_RATIO_CH2      = 3'd3;
    localparam logic [IDX_W-1:0] REG_RATIO_CH3      = 3'd4;

    localparam logic [CNT_W-1:0]   RESET_RECORDS = 6'd32;
    localparam logic [RATIO_W-1:0] RESET_RATIO   = 24'h010000;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    typedef struct packed {
        logic                  is_drain;
        logic [CH_PORT_W-1:0]  channel;
        logic [COPY_W-1:0]     copies;
    } cmd_t;

endpackage

### hw/rtl/multirate_record_ring_assembler_top.sv
// insert: front takes the word while the queue is not full; the back then writes copies slots,
//   one slot write per cycle into the channel's ram column (copies = 0..256)
// drain: a plan state, then a read state and a load state per record for the registered ram read;
//   the load waits while the output is stalled; an empty drain gives its single word after the plan
// a 2-word queue lets the input keep taking words while the back works
// reset: synchronous, active low; positions, marks, accumulators, queue and slot valid bits clear
module multirate_record_ring_assembler_top #(
    parameter int RECORDS   = mrra_pkg::DEF_RECORDS,
    parameter int CHANNELS  = mrra_pkg::DEF_CHANNELS,
    parameter int SLOT_BITS = mrra_pkg::DEF_SLOT_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_op,
    input  logic [mrra_pkg::CH_PORT_W-1:0] s_channel,
    input  logic [mrra_pkg::SLOT_W-1:0]    s_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [mrra_pkg::SLOT_W-1:0]    m_slot0,
    output logic [mrra_pkg::SLOT_W-1:0]    m_slot1,
    output logic [mrra_pkg::SLOT_W-1:0]    m_slot2,
    output logic [mrra_pkg::SLOT_W-1:0]    m_slot3,
    output logic                           m_record_valid,
    output logic                           m_last,
    input  logic                           cfg_wr_en,
    input  logic [mrra_pkg::IDX_W-1:0]     cfg_index,
    input  logic [mrra_pkg::CFG_W-1:0]     cfg_wdata
);

    localparam int Q_W = $bits(mrra_pkg::cmd_t) + SLOT_BITS;

    logic [mrra_pkg::CNT_W-1:0]   records_reg;
    logic [mrra_pkg::RATIO_W-1:0] ratio_reg [mrra_pkg::MAX_CHANNELS];
    logic                         q_push;
    logic                         q_pop;
    logic                         q_full;
    logic                         q_empty;
    logic [Q_W-1:0]               q_wdata;
    logic [Q_W-1:0]               q_rdata;
    mrra_pkg::cmd_t               q_cmd;
    logic [SLOT_BITS-1:0]         q_sample;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            records_reg <= mrra_pkg::RESET_RECORDS;
            for (int c = 0; c < mrra_pkg::MAX_CHANNELS; c++) begin
                ratio_reg[c] <= mrra_pkg::RESET_RATIO;
            end
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mrra_pkg::REG_RECORDS_IN_USE: records_reg  <= cfg_wdata[mrra_pkg::CNT_W-1:0];
                mrra_pkg::REG_RATIO_CH0:      ratio_reg[0] <= cfg_wdata;
                mrra_pkg::REG_RATIO_CH1:      ratio_reg[1] <= cfg_wdata;
                mrra_pkg::REG_RATIO_CH2:      ratio_reg[2] <= cfg_wdata;
                mrra_pkg::REG_RATIO_CH3:      ratio_reg[3] <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    mrra_front #(
        .CHANNELS  (CHANNELS),
        .SLOT_BITS (SLOT_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_op      (s_op),
        .s_channel (s_channel),
        .s_sample  (s_sample),
        .ratio     (ratio_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    mrra_fifo #(
        .WIDTH (Q_W),
        .DEPTH (mrra_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (q_wdata),
        .pop     (q_pop),
        .rd_data (q_rdata),
        .full    (q_full),
        .empty   (q_empty)
    );

    assign {q_cmd, q_sample} = q_rdata;

    mrra_back #(
        .RECORDS   (RECORDS),
        .CHANNELS  (CHANNELS),
        .SLOT_BITS (SLOT_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (q_empty),
        .q_cmd          (q_cmd),
        .q_sample       (q_sample),
        .q_pop          (q_pop),
        .records_in_use (records_reg),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_slot0        (m_slot0),
        .m_slot1        (m_slot1),
        .m_slot2        (m_slot2),
        .m_slot3        (m_slot3),
        .m_record_valid (m_record_valid),
        .m_last         (m_last)
    );

endmodule

### hw/rtl/mrra_ram.sv
// generic single-write, registered-read ram
module mrra_ram #(
    parameter int WIDTH = mrra_pkg::DEF_SLOT_BITS,
    parameter int DEPTH = mrra_pkg::MAX_RECORDS,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### hw/rtl/mrra_fifo.sv
// short command queue between the front and the back
module mrra_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = mrra_pkg::QUEUE_DEPTH,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                mem[wr_ptr_reg] <= wr_data;
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/mrra_front.sv
// input side: takes words, runs the fractional accumulators, queues commands
module mrra_front #(
    parameter int CHANNELS  = mrra_pkg::DEF_CHANNELS,
    parameter int SLOT_BITS = mrra_pkg::DEF_SLOT_BITS,
    localparam int Q_W      = $bits(mrra_pkg::cmd_t) + SLOT_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_op,
    input  logic [mrra_pkg::CH_PORT_W-1:0]  s_channel,
    input  logic [mrra_pkg::SLOT_W-1:0]     s_sample,
    input  logic [mrra_pkg::RATIO_W-1:0]    ratio [mrra_pkg::MAX_CHANNELS],
    input  logic                            q_full,
    output logic                            q_push,
    output logic [Q_W-1:0]                  q_data
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int KEEP = (SLOT_BITS < mrra_pkg::SLOT_W) ? SLOT_BITS : mrra_pkg::SLOT_W;

    logic [mrra_pkg::FRAC_W-1:0] frac_reg [CHANNELS];
    logic [mrra_pkg::ACC_W-1:0]  acc;
    logic                        accept;
    logic                        ch_ok;
    logic                        do_insert;
    logic [CH_W-1:0]             ch_idx;
    logic [SLOT_BITS-1:0]        sample_ext;
    mrra_pkg::cmd_t              cmd;

    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign ch_ok     = ({1'b0, s_channel} < 3'(CHANNELS));
    assign ch_idx    = s_channel[CH_W-1:0];
    assign do_insert = accept && (s_op == mrra_pkg::OP_INSERT) && ch_ok;
    assign acc       = mrra_pkg::ACC_W'(frac_reg[ch_idx])
                     + mrra_pkg::ACC_W'(ratio[s_channel]);

    always_comb begin
        sample_ext = '0;
        sample_ext[KEEP-1:0] = s_sample[KEEP-1:0];
        cmd.is_drain = (s_op == mrra_pkg::OP_DRAIN);
        cmd.channel  = s_channel;
        cmd.copies   = cmd.is_drain ? '0 : acc[mrra_pkg::ACC_W-1:mrra_pkg::FRAC_W];
    end

    // inserts for channels that do not exist are dropped here
    assign q_push = accept && ((s_op == mrra_pkg::OP_DRAIN) || ch_ok);
    assign q_data = {cmd, sample_ext};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                frac_reg[c] <= '0;
            end
        end else if (do_insert) begin
            frac_reg[ch_idx] <= acc[mrra_pkg::FRAC_W-1:0];
        end
    end

endmodule

### hw/rtl/mrra_back.sv
// execution side: slot writes into the ring, drain walks and the output register
module mrra_back #(
    parameter int RECORDS   = mrra_pkg::DEF_RECORDS,
    parameter int CHANNELS  = mrra_pkg::DEF_CHANNELS,
    parameter int SLOT_BITS = mrra_pkg::DEF_SLOT_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_empty,
    input  mrra_pkg::cmd_t                q_cmd,
    input  logic [SLOT_BITS-1:0]          q_sample,
    output logic                          q_pop,
    input  logic [mrra_pkg::CNT_W-1:0]    records_in_use,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic [mrra_pkg::SLOT_W-1:0]   m_slot0,
    output logic [mrra_pkg::SLOT_W-1:0]   m_slot1,
    output logic [mrra_pkg::SLOT_W-1:0]   m_slot2,
    output logic [mrra_pkg::SLOT_W-1:0]   m_slot3,
    output logic                          m_record_valid,
    output logic                          m_last
);

    localparam int REC_DEPTH = (RECORDS < mrra_pkg::MAX_RECORDS) ? RECORDS
                                                                  : mrra_pkg::MAX_RECORDS;
    localparam int AW   = (REC_DEPTH > 1) ? $clog2(REC_DEPTH) : 1;
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int KEEP = (SLOT_BITS < mrra_pkg::SLOT_W) ? SLOT_BITS : mrra_pkg::SLOT_W;
    localparam int CW   = mrra_pkg::CNT_W;
    localparam int PW   = mrra_pkg::POS_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_PLAN,
        ST_RD,
        ST_LD,
        ST_EMPTY
    } state_t;

    state_t                          state_reg;
    logic [CH_W-1:0]                 ch_reg;
    logic [SLOT_BITS-1:0]            sample_reg;
    logic [mrra_pkg::COPY_W-1:0]     cnt_reg;
    logic [PW-1:0]                   write_pos_reg [CHANNELS];
    logic [CHANNELS-1:0]             wrapped_reg;
    logic [CW-1:0]                   read_pos_reg;
    logic [CW-1:0]                   cur_reg;
    logic [CW-1:0]                   a_hi_reg;
    logic [CW-1:0]                   b_hi_reg;
    logic                            in_b_reg;
    logic [CHANNELS-1:0]             valid_reg [REC_DEPTH];
    logic [CHANNELS-1:0]             rd_valid_reg;
    logic                            m_valid_reg;
    logic [mrra_pkg::SLOT_W-1:0]     slot_reg [mrra_pkg::MAX_CHANNELS];
    logic                            rec_valid_reg;
    logic                            last_reg;

    logic [CW-1:0]                   n_eff;
    logic [CW-1:0]                   wp_cur;
    logic [CW-1:0]                   wp_inc;
    logic                            wp_wrap;
    logic [CW-1:0]                   wp_next;
    logic [CW-1:0]                   rp_inc;
    logic [CW-1:0]                   rp_ins_next;
    logic [CW-1:0]                   w_part;
    logic [CW-1:0]                   w_min;
    logic                            all_wrapped;
    logic [CW-1:0]                   first_hi;
    logic [CW-1:0]                   a_hi_plan;
    logic [CW-1:0]                   b_hi_plan;
    logic [CW-1:0]                   rp_plan_next;
    logic                            out_free;
    logic                            load_out;
    logic                            is_last;
    logic [CW-1:0]                   cur_inc;
    logic                            cur_in_range;
    logic [SLOT_BITS-1:0]            ram_rdata [CHANNELS];
    logic [CHANNELS-1:0]             ram_we;
    logic [mrra_pkg::SLOT_W-1:0]     slot_out [mrra_pkg::MAX_CHANNELS];

    // record count limited to 1..depth
    always_comb begin
        if (records_in_use == '0) begin
            n_eff = CW'(1);
        end else if (records_in_use > CW'(REC_DEPTH)) begin
            n_eff = CW'(REC_DEPTH);
        end else begin
            n_eff = records_in_use;
        end
    end

    // one slot write per cycle
    assign wp_cur      = {1'b0, write_pos_reg[ch_reg]};
    assign wp_inc      = wp_cur + 1'b1;
    assign wp_wrap     = (wp_inc >= n_eff);
    assign wp_next     = wp_wrap ? '0 : wp_inc;
    assign rp_inc      = read_pos_reg + 1'b1;
    assign rp_ins_next = (wp_next != read_pos_reg) ? read_pos_reg
                       : ((rp_inc >= n_eff) ? '0 : rp_inc);

    // drain plan: fill limits over channels, never above one past the record count
    always_comb begin
        w_part = n_eff + 1'b1;
        w_min  = n_eff + 1'b1;
        for (int c = 0; c < CHANNELS; c++) begin
            if (wrapped_reg[c]) begin
                if (n_eff < w_part) begin
                    w_part = n_eff;
                end
            end else if ({1'b0, write_pos_reg[c]} < w_part) begin
                w_part = {1'b0, write_pos_reg[c]};
            end
            if ({1'b0, write_pos_reg[c]} < w_min) begin
                w_min = {1'b0, write_pos_reg[c]};
            end
        end
    end

    assign all_wrapped  = &wrapped_reg;
    assign first_hi     = (read_pos_reg < n_eff) ? n_eff : read_pos_reg;
    assign a_hi_plan    = all_wrapped ? first_hi
                        : ((w_part > read_pos_reg) ? w_part : read_pos_reg);
    assign b_hi_plan    = all_wrapped ? w_min : '0;
    assign rp_plan_next = (all_wrapped && (w_min != '0)) ? w_min : a_hi_plan;

    assign out_free     = !m_valid_reg || m_ready;
    assign load_out     = out_free && ((state_reg == ST_LD) || (state_reg == ST_EMPTY));
    assign cur_inc      = cur_reg + 1'b1;
    assign is_last      = in_b_reg ? (cur_inc == b_hi_reg)
                                   : ((cur_inc == a_hi_reg) && (b_hi_reg == '0));
    assign cur_in_range = (cur_reg < CW'(REC_DEPTH));
    assign q_pop        = (state_reg == ST_IDLE) && !q_empty;

    for (genvar g = 0; g < CHANNELS; g++) begin : g_col
        assign ram_we[g] = (state_reg == ST_INS) && (cnt_reg != '0)
                        && (ch_reg == CH_W'(g)) && (wp_cur < CW'(REC_DEPTH));

        mrra_ram #(
            .WIDTH (SLOT_BITS),
            .DEPTH (REC_DEPTH)
        ) u_ram (
            .aclk    (aclk),
            .wr_en   (ram_we[g]),
            .wr_addr (wp_cur[AW-1:0]),
            .wr_data (sample_reg),
            .rd_addr (cur_reg[AW-1:0]),
            .rd_data (ram_rdata[g])
        );
    end

    // slots never written read as zero
    always_comb begin
        for (int c = 0; c < mrra_pkg::MAX_CHANNELS; c++) begin
            slot_out[c] = '0;
        end
        for (int c = 0; c < CHANNELS; c++) begin
            if (rd_valid_reg[c]) begin
                slot_out[c][KEEP-1:0] = ram_rdata[c][KEEP-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            wrapped_reg  <= '0;
            read_pos_reg <= '0;
            cur_reg      <= '0;
            a_hi_reg     <= '0;
            b_hi_reg     <= '0;
            in_b_reg     <= 1'b0;
            rd_valid_reg <= '0;
            m_valid_reg  <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                write_pos_reg[c] <= '0;
            end
            for (int r = 0; r < REC_DEPTH; r++) begin
                valid_reg[r] <= '0;
            end
        end else begin
            rd_valid_reg <= cur_in_range ? valid_reg[cur_reg[AW-1:0]] : '0;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        ch_reg     <= q_cmd.channel[CH_W-1:0];
                        sample_reg <= q_sample;
                        cnt_reg    <= q_cmd.copies;
                        state_reg  <= q_cmd.is_drain ? ST_PLAN : ST_INS;
                    end
                end
                ST_INS: begin
                    if (cnt_reg == '0) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                        if (wp_cur < CW'(REC_DEPTH)) begin
                            valid_reg[wp_cur[AW-1:0]][ch_reg] <= 1'b1;
                        end
                        write_pos_reg[ch_reg] <= wp_next[PW-1:0];
                        if (wp_wrap) begin
                            wrapped_reg[ch_reg] <= 1'b1;
                        end
                        read_pos_reg <= rp_ins_next;
                    end
                end
                ST_PLAN: begin
                    a_hi_reg     <= a_hi_plan;
                    b_hi_reg     <= b_hi_plan;
                    read_pos_reg <= rp_plan_next;
                    if (all_wrapped && (w_min != '0)) begin
                        wrapped_reg <= '0;
                    end
                    if (a_hi_plan == read_pos_reg) begin
                        cur_reg   <= '0;
                        in_b_reg  <= 1'b1;
                        state_reg <= (b_hi_plan == '0) ? ST_EMPTY : ST_RD;
                    end else begin
                        cur_reg   <= read_pos_reg;
                        in_b_reg  <= 1'b0;
                        state_reg <= ST_RD;
                    end
                end
                ST_RD: begin
                    // address settles, ram data lands next cycle
                    state_reg <= ST_LD;
                end
                ST_LD: begin
                    if (out_free) begin
                        rec_valid_reg <= 1'b1;
                        last_reg      <= is_last;
                        for (int c = 0; c < mrra_pkg::MAX_CHANNELS; c++) begin
                            slot_reg[c] <= slot_out[c];
                        end
                        if (is_last) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            if (!in_b_reg && (cur_inc == a_hi_reg)) begin
                                cur_reg  <= '0;
                                in_b_reg <= 1'b1;
                            end else begin
                                cur_reg <= cur_inc;
                            end
                            state_reg <= ST_RD;
                        end
                    end
                end
                ST_EMPTY: begin
                    if (out_free) begin
                        rec_valid_reg <= 1'b0;
                        last_reg      <= 1'b1;
                        for (int c = 0; c < mrra_pkg::MAX_CHANNELS; c++) begin
                            slot_reg[c] <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_slot0        = slot_reg[0];
    assign m_slot1        = slot_reg[1];
    assign m_slot2        = slot_reg[2];
    assign m_slot3        = slot_reg[3];
    assign m_record_valid = rec_valid_reg;
    assign m_last         = last_reg;

endmodule

### hw/rtl/mrra_checker.sv
// port checker for the record ring assembler, bound to the top level
module mrra_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [mrra_pkg::SLOT_W-1:0] m_slot0,
    input logic [mrra_pkg::SLOT_W-1:0] m_slot1,
    input logic [mrra_pkg::SLOT_W-1:0] m_slot2,
    input logic [mrra_pkg::SLOT_W-1:0] m_slot3,
    input logic                        m_record_valid,
    input logic                        m_last
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_slot0) && $stable(m_slot1) && $stable(m_slot2)
            && $stable(m_slot3) && $stable(m_record_valid) && $stable(m_last))
        else $error("output word changed while stalled");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_record_valid |-> m_last)
        else $error("empty drain word without last");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_record_valid |-> (m_slot0 == '0) && (m_slot1 == '0)
            && (m_slot2 == '0) && (m_slot3 == '0))
        else $error("empty drain word carries slot data");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule

bind multirate_record_ring_assembler_top mrra_checker u_mrra_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_slot0        (m_slot0),
    .m_slot1        (m_slot1),
    .m_slot2        (m_slot2),
    .m_slot3        (m_slot3),
    .m_record_valid (m_record_valid),
    .m_last         (m_last)
);
